// ----- src/lacs_pkg.sv -----
// Shared types, codes and helper functions of the life automaton change stream block.
package lacs_pkg;

    // Default board size.
    localparam int DEFAULT_COLS = 80;
    localparam int DEFAULT_ROWS = 60;

    // Depth of the command queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;

    // Operation codes on the input channel.
    localparam logic [1:0] OP_SET   = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_STEP  = 2'd2;

    // Commands handed from the front to the back.
    typedef enum logic [1:0] {
        CMD_SET,
        CMD_CLEAR,
        CMD_ROW
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t  kind;
        logic       bank;
        logic       value;
        logic [2:0] bit_pos;
        logic       last_row;
    } cmd_ctrl_t;

    // Back end sequencer states.
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SET_RD,
        ST_SET_WR,
        ST_FETCH,
        ST_EVAL
    } back_state_t;

    // Progress through one row: two preload fetches, then the group run.
    typedef enum logic [1:0] {
        PH_LAST,
        PH_FIRST,
        PH_RUN
    } row_phase_t;

    // Number of set bits in a byte.
    function automatic logic [3:0] count8(input logic [7:0] v);
        logic [3:0] sum;
        sum = '0;
        for (int i = 0; i < 8; i++)
        begin
            sum = sum + {3'b000, v[i]};
        end
        return sum;
    endfunction

    // Birth on three neighbors, survival on two or three.
    function automatic logic life_rule(input logic alive, input logic [3:0] n);
        return (n == 4'd3) || (alive && (n == 4'd2));
    endfunction

endpackage

// ----- src/lacs_front.sv -----
// Front end: accepts input transfers, filters ignored operations and builds commands.
module lacs_front #(
    parameter int BOARD_COLS = lacs_pkg::DEFAULT_COLS,
    parameter int BOARD_ROWS = lacs_pkg::DEFAULT_ROWS
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    item_valid,
    output logic                    item_stall,
    input  logic [1:0]              operation,
    input  logic [6:0]              cell_x,
    input  logic [5:0]              cell_y,
    input  logic                    cell_value,
    input  logic                    init_done,
    input  logic                    queue_full,
    output logic                    push,
    output lacs_pkg::cmd_ctrl_t     cmd_ctrl,
    output logic [$clog2(BOARD_ROWS)-1:0] cmd_row,
    output logic [$clog2(BOARD_ROWS*((BOARD_COLS+7)/8))-1:0] cmd_addr,
    output logic [$clog2(BOARD_ROWS*((BOARD_COLS+7)/8))-1:0] cmd_up,
    output logic [$clog2(BOARD_ROWS*((BOARD_COLS+7)/8))-1:0] cmd_dn
);

    localparam int GROUPS = (BOARD_COLS + 7) / 8;
    localparam int DEPTH  = BOARD_ROWS * GROUPS;
    localparam int AW     = $clog2(DEPTH);
    localparam int RW     = $clog2(BOARD_ROWS);
    localparam logic [AW-1:0] STRIDE    = AW'(GROUPS);
    localparam logic [AW-1:0] LAST_BASE = AW'((BOARD_ROWS - 1) * GROUPS);
    localparam logic [RW-1:0] LAST_ROW  = RW'(BOARD_ROWS - 1);

    logic [RW-1:0] row_cnt_reg, row_cnt_next;
    logic [AW-1:0] row_base_reg, row_base_next;
    logic          bank_reg, bank_next;

    logic          accept;
    logic          row_zero;
    logic          row_last;
    logic          x_ok;
    logic          y_ok;
    logic [AW-1:0] set_addr;
    logic [AW-1:0] up_base;
    logic [AW-1:0] dn_base;

    assign item_stall = !init_done || queue_full;
    assign accept     = item_valid && !item_stall;
    assign row_zero   = (row_cnt_reg == '0);
    assign row_last   = (row_cnt_reg == LAST_ROW);
    assign x_ok       = 32'(cell_x) < 32'(BOARD_COLS);
    assign y_ok       = 32'(cell_y) < 32'(BOARD_ROWS);
    assign set_addr   = AW'(32'(cell_y) * 32'(GROUPS) + 32'(cell_x >> 3));
    assign up_base    = row_zero ? LAST_BASE : row_base_reg - STRIDE;
    assign dn_base    = row_last ? '0 : row_base_reg + STRIDE;

    assign cmd_row = row_cnt_reg;
    assign cmd_up  = up_base;
    assign cmd_dn  = dn_base;

    always_comb
    begin
        push              = 1'b0;
        cmd_ctrl.kind     = lacs_pkg::CMD_ROW;
        cmd_ctrl.bank     = bank_reg;
        cmd_ctrl.value    = cell_value;
        cmd_ctrl.bit_pos  = cell_x[2:0];
        cmd_ctrl.last_row = row_last;
        cmd_addr          = row_base_reg;
        row_cnt_next      = row_cnt_reg;
        row_base_next     = row_base_reg;
        bank_next         = bank_reg;
        unique case (operation)
            lacs_pkg::OP_SET:
            begin
                cmd_ctrl.kind = lacs_pkg::CMD_SET;
                cmd_addr      = set_addr;
                push          = accept && row_zero && x_ok && y_ok;
            end
            lacs_pkg::OP_CLEAR:
            begin
                cmd_ctrl.kind = lacs_pkg::CMD_CLEAR;
                push          = accept && row_zero;
            end
            lacs_pkg::OP_STEP:
            begin
                push = accept;
                if (accept)
                begin
                    row_cnt_next  = row_last ? '0 : row_cnt_reg + 1'b1;
                    row_base_next = dn_base;
                    bank_next     = row_last ? !bank_reg : bank_reg;
                end
            end
            default:
            begin
                push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_cnt_reg  <= '0;
            row_base_reg <= '0;
            bank_reg     <= 1'b0;
        end
        else
        begin
            row_cnt_reg  <= row_cnt_next;
            row_base_reg <= row_base_next;
            bank_reg     <= bank_next;
        end
    end

endmodule

// ----- src/lacs_queue.sv -----
// Small command queue that decouples the front end from the back end.
module lacs_queue #(
    parameter int DATA_W = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [DATA_W-1:0] wdata,
    output logic              full,
    input  logic              pop,
    output logic              not_empty,
    output logic [DATA_W-1:0] rdata
);

    localparam int DEPTH = lacs_pkg::QUEUE_DEPTH;
    localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    logic [DATA_W-1:0] slot_reg [DEPTH];
    logic [PW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]     count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    assign full      = (count_reg == FULL_CNT);
    assign not_empty = (count_reg != '0);
    assign rdata     = slot_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// ----- src/lacs_back.sv -----
// Back end: board memories, row evaluation sequencer and result register.
module lacs_back #(
    parameter int BOARD_COLS = lacs_pkg::DEFAULT_COLS,
    parameter int BOARD_ROWS = lacs_pkg::DEFAULT_ROWS
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cmd_valid,
    output logic                    cmd_pop,
    input  lacs_pkg::cmd_ctrl_t     cmd_ctrl,
    input  logic [$clog2(BOARD_ROWS)-1:0] cmd_row,
    input  logic [$clog2(BOARD_ROWS*((BOARD_COLS+7)/8))-1:0] cmd_addr,
    input  logic [$clog2(BOARD_ROWS*((BOARD_COLS+7)/8))-1:0] cmd_up,
    input  logic [$clog2(BOARD_ROWS*((BOARD_COLS+7)/8))-1:0] cmd_dn,
    output logic                    init_done,
    output logic                    result_valid,
    input  logic                    result_stall,
    output logic [5:0]              row_index,
    output logic [3:0]              group_index,
    output logic [7:0]              new_bits,
    output logic [7:0]              change_mask,
    output logic                    last_of_row,
    output logic                    generation_done
);

    localparam int GROUPS    = (BOARD_COLS + 7) / 8;
    localparam int DEPTH     = BOARD_ROWS * GROUPS;
    localparam int AW        = $clog2(DEPTH);
    localparam int RW        = $clog2(BOARD_ROWS);
    localparam int GW        = (GROUPS > 1) ? $clog2(GROUPS) : 1;
    localparam int LAST_LANE = (BOARD_COLS - 1) % 8;
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
    localparam logic [GW-1:0] LAST_GRP  = GW'(GROUPS - 1);

    // Board banks, one per generation buffer.
    logic [7:0] mem0 [DEPTH];
    logic [7:0] mem1 [DEPTH];

    lacs_pkg::back_state_t state_reg, state_next;
    lacs_pkg::row_phase_t  phase_reg;
    lacs_pkg::cmd_ctrl_t   ctrl_reg;

    logic [AW-1:0] clr_addr_reg;
    logic [1:0]    k_reg;
    logic [GW-1:0] grp_reg;
    logic [GW-1:0] fgrp_reg;
    logic [RW-1:0] row_reg;
    logic [AW-1:0] base_reg [3];
    logic          init_done_reg;

    // Three-row window: previous, current, fetched and first groups.
    logic [7:0] prev_reg  [3];
    logic [7:0] cur_reg   [3];
    logic [7:0] nwin_reg  [3];
    logic [7:0] first_reg [3];

    logic       result_valid_reg;
    logic [5:0] row_index_reg;
    logic [3:0] group_index_reg;
    logic [7:0] new_bits_reg;
    logic [7:0] change_mask_reg;
    logic       last_of_row_reg;
    logic       generation_done_reg;

    logic          out_free;
    logic          emit;
    logic          we0;
    logic          we1;
    logic [AW-1:0] waddr;
    logic [7:0]    wdata;
    logic          re;
    logic          rbank;
    logic [1:0]    rk;
    logic [AW-1:0] raddr;
    logic [AW-1:0] fetch_addr;
    logic [7:0]    set_mask;

    logic          grp_first;
    logic          grp_last;
    logic [7:0]    nb       [3];
    logic [9:0]    ext      [3];
    logic [2:0]    rbit;
    logic [7:0]    nbr;
    logic [7:0]    new_c;
    logic [7:0]    old_c;

    assign out_free   = !result_valid_reg || !result_stall;
    assign fetch_addr = base_reg[k_reg] + AW'(fgrp_reg);
    assign set_mask   = 8'(1) << ctrl_reg.bit_pos;
    assign grp_first  = (grp_reg == '0);
    assign grp_last   = (grp_reg == LAST_GRP);
    assign init_done  = init_done_reg;

    // Eight cells of the group in parallel, each from its 3x3 neighborhood.
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            nb[k]  = grp_last ? first_reg[k] : nwin_reg[k];
            ext[k] = {nb[k][0], cur_reg[k],
                      grp_first ? prev_reg[k][LAST_LANE] : prev_reg[k][7]};
        end
        for (int i = 0; i < 8; i++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                rbit[k] = (grp_last && (i == LAST_LANE)) ? first_reg[k][0] : ext[k][i + 2];
            end
            nbr = {ext[0][i], ext[0][i + 1], rbit[0],
                   ext[1][i], rbit[1],
                   ext[2][i], ext[2][i + 1], rbit[2]};
            if (!grp_last || (i <= LAST_LANE))
            begin
                new_c[i] = lacs_pkg::life_rule(cur_reg[1][i], lacs_pkg::count8(nbr));
                old_c[i] = cur_reg[1][i];
            end
            else
            begin
                new_c[i] = 1'b0;
                old_c[i] = 1'b0;
            end
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lacs_pkg::ST_CLEAR:
            begin
                if (clr_addr_reg == LAST_ADDR)
                begin
                    state_next = lacs_pkg::ST_IDLE;
                end
            end
            lacs_pkg::ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    unique case (cmd_ctrl.kind)
                        lacs_pkg::CMD_SET:   state_next = lacs_pkg::ST_SET_RD;
                        lacs_pkg::CMD_CLEAR: state_next = lacs_pkg::ST_CLEAR;
                        lacs_pkg::CMD_ROW:   state_next = lacs_pkg::ST_FETCH;
                        default:             state_next = lacs_pkg::ST_IDLE;
                    endcase
                end
            end
            lacs_pkg::ST_SET_RD:
            begin
                state_next = lacs_pkg::ST_SET_WR;
            end
            lacs_pkg::ST_SET_WR:
            begin
                state_next = lacs_pkg::ST_IDLE;
            end
            lacs_pkg::ST_FETCH:
            begin
                if (k_reg == 2'd2)
                begin
                    state_next = lacs_pkg::ST_EVAL;
                end
            end
            lacs_pkg::ST_EVAL:
            begin
                unique case (phase_reg)
                    lacs_pkg::PH_LAST:
                    begin
                        state_next = lacs_pkg::ST_FETCH;
                    end
                    lacs_pkg::PH_FIRST:
                    begin
                        state_next = (GROUPS == 1) ? lacs_pkg::ST_EVAL : lacs_pkg::ST_FETCH;
                    end
                    lacs_pkg::PH_RUN:
                    begin
                        if (out_free)
                        begin
                            priority if (grp_last)
                            begin
                                state_next = lacs_pkg::ST_IDLE;
                            end
                            else if (grp_reg + 1'b1 == LAST_GRP)
                            begin
                                state_next = lacs_pkg::ST_EVAL;
                            end
                            else
                            begin
                                state_next = lacs_pkg::ST_FETCH;
                            end
                        end
                    end
                    default:
                    begin
                        state_next = lacs_pkg::ST_IDLE;
                    end
                endcase
            end
            default:
            begin
                state_next = lacs_pkg::ST_IDLE;
            end
        endcase
    end

    // Memory ports and handshake outputs.
    always_comb
    begin
        cmd_pop = 1'b0;
        emit    = 1'b0;
        we0     = 1'b0;
        we1     = 1'b0;
        waddr   = base_reg[1];
        wdata   = '0;
        re      = 1'b0;
        rbank   = ctrl_reg.bank;
        rk      = k_reg;
        raddr   = fetch_addr;
        unique case (state_reg)
            lacs_pkg::ST_CLEAR:
            begin
                we0   = 1'b1;
                we1   = 1'b1;
                waddr = clr_addr_reg;
            end
            lacs_pkg::ST_IDLE:
            begin
                cmd_pop = cmd_valid;
            end
            lacs_pkg::ST_SET_RD:
            begin
                re    = 1'b1;
                rk    = 2'd0;
                raddr = base_reg[1];
            end
            lacs_pkg::ST_SET_WR:
            begin
                we0   = !ctrl_reg.bank;
                we1   = ctrl_reg.bank;
                wdata = ctrl_reg.value ? (nwin_reg[0] | set_mask) : (nwin_reg[0] & ~set_mask);
            end
            lacs_pkg::ST_FETCH:
            begin
                re = 1'b1;
            end
            lacs_pkg::ST_EVAL:
            begin
                emit  = (phase_reg == lacs_pkg::PH_RUN) && out_free;
                we0   = emit && ctrl_reg.bank;
                we1   = emit && !ctrl_reg.bank;
                waddr = base_reg[1] + AW'(grp_reg);
                wdata = new_c;
            end
            default:
            begin
                cmd_pop = 1'b0;
            end
        endcase
    end

    // Sequencer control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lacs_pkg::ST_CLEAR;
            phase_reg     <= lacs_pkg::PH_LAST;
            clr_addr_reg  <= '0;
            k_reg         <= '0;
            grp_reg       <= '0;
            fgrp_reg      <= '0;
            init_done_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                lacs_pkg::ST_CLEAR:
                begin
                    clr_addr_reg <= clr_addr_reg + 1'b1;
                    if (clr_addr_reg == LAST_ADDR)
                    begin
                        init_done_reg <= 1'b1;
                    end
                end
                lacs_pkg::ST_IDLE:
                begin
                    clr_addr_reg <= '0;
                    phase_reg    <= lacs_pkg::PH_LAST;
                    fgrp_reg     <= LAST_GRP;
                    k_reg        <= '0;
                end
                lacs_pkg::ST_FETCH:
                begin
                    k_reg <= (k_reg == 2'd2) ? 2'd0 : k_reg + 1'b1;
                end
                lacs_pkg::ST_EVAL:
                begin
                    unique case (phase_reg)
                        lacs_pkg::PH_LAST:
                        begin
                            phase_reg <= lacs_pkg::PH_FIRST;
                            fgrp_reg  <= '0;
                        end
                        lacs_pkg::PH_FIRST:
                        begin
                            phase_reg <= lacs_pkg::PH_RUN;
                            grp_reg   <= '0;
                            fgrp_reg  <= GW'(1);
                        end
                        lacs_pkg::PH_RUN:
                        begin
                            if (emit)
                            begin
                                grp_reg  <= grp_reg + 1'b1;
                                fgrp_reg <= grp_reg + GW'(2);
                            end
                        end
                        default:
                        begin
                            phase_reg <= lacs_pkg::PH_LAST;
                        end
                    endcase
                end
                default:
                begin
                    k_reg <= k_reg;
                end
            endcase
        end
    end

    // Command fields and the row window.
    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            ctrl_reg    <= cmd_ctrl;
            row_reg     <= cmd_row;
            base_reg[0] <= cmd_up;
            base_reg[1] <= cmd_addr;
            base_reg[2] <= cmd_dn;
        end
        if (state_reg == lacs_pkg::ST_EVAL)
        begin
            if (phase_reg != lacs_pkg::PH_RUN || emit)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    prev_reg[k] <= cur_reg[k];
                    cur_reg[k]  <= (phase_reg == lacs_pkg::PH_RUN) ? nb[k] : nwin_reg[k];
                end
            end
            if (phase_reg == lacs_pkg::PH_FIRST)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    first_reg[k] <= nwin_reg[k];
                end
            end
        end
    end

    // Memory write and registered read.
    always_ff @(posedge clk)
    begin
        if (we0)
        begin
            mem0[waddr] <= wdata;
        end
        if (we1)
        begin
            mem1[waddr] <= wdata;
        end
        if (re)
        begin
            if (rbank)
            begin
                nwin_reg[rk] <= mem1[raddr];
            end
            else
            begin
                nwin_reg[rk] <= mem0[raddr];
            end
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            row_index_reg       <= 6'(row_reg);
            group_index_reg     <= 4'(grp_reg);
            new_bits_reg        <= new_c;
            change_mask_reg     <= new_c ^ old_c;
            last_of_row_reg     <= grp_last;
            generation_done_reg <= grp_last && ctrl_reg.last_row;
        end
    end

    assign result_valid    = result_valid_reg;
    assign row_index       = row_index_reg;
    assign group_index     = group_index_reg;
    assign new_bits        = new_bits_reg;
    assign change_mask     = change_mask_reg;
    assign last_of_row     = last_of_row_reg;
    assign generation_done = generation_done_reg;

    a_done_implies_row_end: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && generation_done_reg |-> last_of_row_reg)
        else $error("generation_done without last_of_row");

    a_init_stays: assert property (@(posedge clk) disable iff (!rst_n)
        !$fell(init_done_reg))
        else $error("initial clear flag dropped");

    a_row_starts_fetch: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop && cmd_ctrl.kind == lacs_pkg::CMD_ROW |=> state_reg == lacs_pkg::ST_FETCH)
        else $error("row command did not start fetching");

    a_last_group_ends: assert property (@(posedge clk) disable iff (!rst_n)
        emit && grp_last |=> state_reg == lacs_pkg::ST_IDLE && result_valid_reg)
        else $error("row did not finish after its last group");

endmodule

// ----- src/life_automaton_change_stream_top.sv -----
// Top level of the toroidal life automaton that streams per-group changes.
// In the back end a set cell reads and then rewrites its byte; clear writes one board byte a cycle (600 by default).
// In a row step every group needs three byte reads through the single read port
// of the board memory, plus a two-fetch preload.
// After reset the board is swept to zero, one byte a cycle, and item_stall stays high meanwhile.
module life_automaton_change_stream_top #(
    parameter int BOARD_COLS = lacs_pkg::DEFAULT_COLS,
    parameter int BOARD_ROWS = lacs_pkg::DEFAULT_ROWS
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_stall,
    input  logic [1:0] operation,
    input  logic [6:0] cell_x,
    input  logic [5:0] cell_y,
    input  logic       cell_value,
    output logic       result_valid,
    input  logic       result_stall,
    output logic [5:0] row_index,
    output logic [3:0] group_index,
    output logic [7:0] new_bits,
    output logic [7:0] change_mask,
    output logic       last_of_row,
    output logic       generation_done
);

    // The board is stored as bytes of eight cells, GROUPS bytes per row.
    localparam int GROUPS = (BOARD_COLS + 7) / 8;
    localparam int DEPTH  = BOARD_ROWS * GROUPS;
    localparam int AW     = $clog2(DEPTH);
    localparam int RW     = $clog2(BOARD_ROWS);
    localparam int CMD_W  = $bits(lacs_pkg::cmd_ctrl_t) + RW + 3 * AW;

    // Front end command, as pushed into the queue.
    lacs_pkg::cmd_ctrl_t f_ctrl;
    logic [RW-1:0]       f_row;
    logic [AW-1:0]       f_addr;
    logic [AW-1:0]       f_up;
    logic [AW-1:0]       f_dn;
    logic                f_push;

    // Back end command, as popped from the queue.
    lacs_pkg::cmd_ctrl_t b_ctrl;
    logic [RW-1:0]       b_row;
    logic [AW-1:0]       b_addr;
    logic [AW-1:0]       b_up;
    logic [AW-1:0]       b_dn;
    logic                b_pop;

    logic [CMD_W-1:0]    q_wdata;
    logic [CMD_W-1:0]    q_rdata;
    logic                q_full;
    logic                q_not_empty;
    logic                init_done;

    // The front end tracks the row counter and bank select at transfer time, so
    // every command already carries its bank, and a step command its row and the three
    // row base addresses; ignored operations never reach the queue.
    lacs_front #(
        .BOARD_COLS (BOARD_COLS),
        .BOARD_ROWS (BOARD_ROWS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .operation  (operation),
        .cell_x     (cell_x),
        .cell_y     (cell_y),
        .cell_value (cell_value),
        .init_done  (init_done),
        .queue_full (q_full),
        .push       (f_push),
        .cmd_ctrl   (f_ctrl),
        .cmd_row    (f_row),
        .cmd_addr   (f_addr),
        .cmd_up     (f_up),
        .cmd_dn     (f_dn)
    );

    assign q_wdata = {f_ctrl, f_row, f_up, f_dn, f_addr};

    lacs_queue #(
        .DATA_W (CMD_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (f_push),
        .wdata     (q_wdata),
        .full      (q_full),
        .pop       (b_pop),
        .not_empty (q_not_empty),
        .rdata     (q_rdata)
    );

    assign {b_ctrl, b_row, b_up, b_dn, b_addr} = q_rdata;

    // The back end owns both board banks and the result register, so a row keeps
    // computing while the front end takes further transfers into the queue.
    lacs_back #(
        .BOARD_COLS (BOARD_COLS),
        .BOARD_ROWS (BOARD_ROWS)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd_valid       (q_not_empty),
        .cmd_pop         (b_pop),
        .cmd_ctrl        (b_ctrl),
        .cmd_row         (b_row),
        .cmd_addr        (b_addr),
        .cmd_up          (b_up),
        .cmd_dn          (b_dn),
        .init_done       (init_done),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .row_index       (row_index),
        .group_index     (group_index),
        .new_bits        (new_bits),
        .change_mask     (change_mask),
        .last_of_row     (last_of_row),
        .generation_done (generation_done)
    );

endmodule

// ----- test/testbench.sv -----
// Self-checking testbench of the streamed toroidal life automaton, with its own board predictor.
`timescale 1ns / 1ps

module testbench;

    localparam int BOARD_COLS = lacs_pkg::DEFAULT_COLS;
    localparam int BOARD_ROWS = lacs_pkg::DEFAULT_ROWS;
    localparam int GROUPS = (BOARD_COLS + 7) / 8;

    // The block ignores operation code 3; it has no name in the package.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // Counted random transfers, the length of the receiver hold-off, the settling time
    // after the last result and the run limit.
    localparam int RANDOM_ITEMS = 78;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 100;
    localparam int TIMEOUT_NS = 3_000_000;

    // One input transfer.
    typedef struct packed {
        logic [1:0] op;
        logic [6:0] x;
        logic [5:0] y;
        logic       v;
    } life_item_t;

    // One result transfer: the next state of one 8-cell group.
    typedef struct packed {
        logic [5:0] row_idx;
        logic [3:0] group_idx;
        logic [7:0] bits;
        logic [7:0] changed;
        logic       row_end;
        logic       gen_end;
    } group_result_t;

    // A row of the directed script. When known is set, the expected results are the ones
    // typed here: nothing for a set, clear or unused code, and for a step every group
    // zero except the first (first_bits) and the last (last_bits), with no changes.
    typedef struct packed {
        life_item_t item;
        logic       known;
        logic [7:0] first_bits;
        logic [7:0] last_bits;
    } script_row_t;

    // Pacing of the two sides of the block.
    typedef enum logic [2:0] {
        PACE_FREE,
        PACE_HOLD,
        PACE_SENDER,
        PACE_RECEIVER,
        PACE_BOTH
    } pace_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       item_valid = 1'b0;
    logic       item_stall;
    logic [1:0] operation = lacs_pkg::OP_SET;
    logic [6:0] cell_x = '0;
    logic [5:0] cell_y = '0;
    logic       cell_value = 1'b0;
    logic       result_valid;
    logic       result_stall = 1'b0;
    logic [5:0] row_index;
    logic [3:0] group_index;
    logic [7:0] new_bits;
    logic [7:0] change_mask;
    logic       last_of_row;
    logic       generation_done;

    // Predicted board: the generation being read and the one being built.
    bit alive_now [BOARD_ROWS][BOARD_COLS];
    bit alive_next [BOARD_ROWS][BOARD_COLS];
    int row_cursor = 0;

    group_result_t expected_groups[$];
    script_row_t   script_rows[$];
    int            mismatch_count = 0;
    pace_t         pace = PACE_FREE;
    int            hold_left = 0;
    bit            hold_done = 1'b0;

    life_automaton_change_stream_top dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .item_valid      (item_valid),
        .item_stall      (item_stall),
        .operation       (operation),
        .cell_x          (cell_x),
        .cell_y          (cell_y),
        .cell_value      (cell_value),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .row_index       (row_index),
        .group_index     (group_index),
        .new_bits        (new_bits),
        .change_mask     (change_mask),
        .last_of_row     (last_of_row),
        .generation_done (generation_done)
    );

    always #5 clk = ~clk;

    // Applies one accepted transfer to the predicted board and returns the results that
    // it causes. Set and clear only act between generations; a set off the board and the
    // unused code do nothing. A step evaluates the row under the cursor with wraparound
    // on both axes, and the last row of a generation makes the new board current.
    function automatic void advance_board(input life_item_t it, ref group_result_t produced[$]);
        group_result_t res;
        int r, up, dn, g, i, x, lf, rt, n;
        bit was_alive, will_live;
        produced.delete();
        case (it.op)
            lacs_pkg::OP_SET:
            begin
                if (row_cursor == 0 && it.x < BOARD_COLS && it.y < BOARD_ROWS)
                    alive_now[it.y][it.x] = it.v;
            end
            lacs_pkg::OP_CLEAR:
            begin
                if (row_cursor == 0)
                begin
                    for (r = 0; r < BOARD_ROWS; r++)
                    begin
                        for (x = 0; x < BOARD_COLS; x++)
                        begin
                            alive_now[r][x] = 1'b0;
                            alive_next[r][x] = 1'b0;
                        end
                    end
                end
            end
            lacs_pkg::OP_STEP:
            begin
                r = row_cursor;
                up = (r == 0) ? BOARD_ROWS - 1 : r - 1;
                dn = (r + 1 >= BOARD_ROWS) ? 0 : r + 1;
                for (g = 0; g < GROUPS; g++)
                begin
                    res = '0;
                    for (i = 0; i < 8; i++)
                    begin
                        x = g * 8 + i;
                        if (x < BOARD_COLS)
                        begin
                            lf = (x == 0) ? BOARD_COLS - 1 : x - 1;
                            rt = (x + 1 >= BOARD_COLS) ? 0 : x + 1;
                            n = alive_now[up][lf] + alive_now[up][x] + alive_now[up][rt]
                              + alive_now[r][lf] + alive_now[r][rt]
                              + alive_now[dn][lf] + alive_now[dn][x] + alive_now[dn][rt];
                            was_alive = alive_now[r][x];
                            will_live = (n == 3) || (was_alive && n == 2);
                            alive_next[r][x] = will_live;
                            res.bits[i] = will_live;
                            res.changed[i] = will_live ^ was_alive;
                        end
                    end
                    res.row_idx = r[5:0];
                    res.group_idx = g[3:0];
                    res.row_end = (g == GROUPS - 1);
                    res.gen_end = (g == GROUPS - 1) && (r == BOARD_ROWS - 1);
                    produced.push_back(res);
                end
                if (r == BOARD_ROWS - 1)
                begin
                    for (r = 0; r < BOARD_ROWS; r++)
                    begin
                        for (x = 0; x < BOARD_COLS; x++)
                            alive_now[r][x] = alive_next[r][x];
                    end
                    row_cursor = 0;
                end
                else
                begin
                    row_cursor = r + 1;
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    function automatic bit field_matches(input string name, input logic [7:0] want,
                                         input logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            return 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic add_row(input logic [1:0] op, input int x, input int y, input bit v,
                           input bit known, input logic [7:0] first_bits,
                           input logic [7:0] last_bits);
        script_row_t row;
        row.item.op = op;
        row.item.x = 7'(x);
        row.item.y = 6'(y);
        row.item.v = v;
        row.known = known;
        row.first_bits = first_bits;
        row.last_bits = last_bits;
        script_rows.push_back(row);
    endtask

    // Offers one transfer and holds it until the block takes it. The valid line is left
    // high on return, so a following transfer with no gap keeps it high without a dip.
    // On acceptance the predictor runs and the expected results are queued.
    task automatic offer_item(input life_item_t it, input bit known,
                              input logic [7:0] first_bits, input logic [7:0] last_bits);
        group_result_t predicted[$];
        group_result_t typed_res;
        int gap_pct, row_now, g;
        gap_pct = (pace == PACE_SENDER) ? 55 : (pace == PACE_BOTH) ? 9 : 0;
        while ($urandom_range(0, 99) < gap_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        operation <= it.op;
        cell_x <= it.x;
        cell_y <= it.y;
        cell_value <= it.v;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        row_now = row_cursor;
        advance_board(it, predicted);
        if (!known)
        begin
            foreach (predicted[k])
                expected_groups.push_back(predicted[k]);
        end
        else if (it.op == lacs_pkg::OP_STEP)
        begin
            for (g = 0; g < GROUPS; g++)
            begin
                typed_res = '0;
                typed_res.row_idx = row_now[5:0];
                typed_res.group_idx = g[3:0];
                typed_res.bits = (g == 0) ? first_bits : (g == GROUPS - 1) ? last_bits : 8'h00;
                typed_res.row_end = (g == GROUPS - 1);
                expected_groups.push_back(typed_res);
            end
        end
    endtask

    // Result side: every transfer is compared field by field with the oldest expectation,
    // then the stall for the next cycle is chosen. The first time the pacing asks for a
    // hold, the receiver stalls for a long stretch so that the block backs up into its
    // input; the sender keeps offering transfers meanwhile.
    always @(posedge clk)
    begin : result_side
        group_result_t want;
        int stall_pct;
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_groups.size() == 0)
            begin
                $error("result with nothing expected: row_index %0d group_index %0d",
                       row_index, group_index);
                mismatch_count++;
            end
            else
            begin
                want = expected_groups.pop_front();
                if (!field_matches("row_index", 8'(want.row_idx), 8'(row_index)))
                    mismatch_count++;
                if (!field_matches("group_index", 8'(want.group_idx), 8'(group_index)))
                    mismatch_count++;
                if (!field_matches("new_bits", want.bits, new_bits))
                    mismatch_count++;
                if (!field_matches("change_mask", want.changed, change_mask))
                    mismatch_count++;
                if (!field_matches("last_of_row", 8'(want.row_end), 8'(last_of_row)))
                    mismatch_count++;
                if (!field_matches("generation_done", 8'(want.gen_end),
                                   8'(generation_done)))
                    mismatch_count++;
            end
        end
        stall_pct = (pace == PACE_RECEIVER) ? 55 : (pace == PACE_BOTH) ? 9 : 0;
        if (hold_left > 0)
        begin
            hold_left--;
            result_stall <= 1'b1;
        end
        else if (pace == PACE_HOLD && !hold_done)
        begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            result_stall <= 1'b1;
        end
        else
        begin
            result_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    initial
    begin : stimulus
        life_item_t it;
        int counted, roll, seeds_left, seed_col, seed_row;
        bit counts, wipe_next;
        counted = 0;
        seeds_left = 0;
        seed_col = 0;
        seed_row = 0;
        wipe_next = 1'b0;

        // The board is swept to zero after reset; the input stalls until that is done.
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part. A lone cell that a clear wipes out, then a block of four live
        // cells made of the four corners, which only touch each other across the wrapped
        // edges and so stay alive. Sets off the board and the unused code are dropped, a
        // cell is raised and then killed, and a blinker straddles two groups in row 20.
        add_row(lacs_pkg::OP_SET, 3, 3, 1, 0, 8'h00, 8'h00);
        add_row(lacs_pkg::OP_CLEAR, 0, 0, 0, 1, 8'h00, 8'h00);
        add_row(lacs_pkg::OP_SET, 0, 0, 1, 1, 8'h00, 8'h00);
        add_row(lacs_pkg::OP_SET, 79, 0, 1, 1, 8'h00, 8'h00);
        add_row(lacs_pkg::OP_SET, 0, 59, 1, 1, 8'h00, 8'h00);
        add_row(lacs_pkg::OP_SET, 79, 59, 1, 1, 8'h00, 8'h00);
        add_row(lacs_pkg::OP_SET, 127, 63, 1, 1, 8'h00, 8'h00);
        add_row(lacs_pkg::OP_SET, 80, 5, 1, 1, 8'h00, 8'h00);
        add_row(lacs_pkg::OP_SET, 5, 60, 1, 1, 8'h00, 8'h00);
        add_row(lacs_pkg::OP_SET, 39, 20, 1, 0, 8'h00, 8'h00);
        add_row(lacs_pkg::OP_SET, 40, 20, 1, 0, 8'h00, 8'h00);
        add_row(lacs_pkg::OP_SET, 41, 20, 1, 0, 8'h00, 8'h00);
        add_row(lacs_pkg::OP_SET, 10, 10, 1, 0, 8'h00, 8'h00);
        add_row(lacs_pkg::OP_SET, 10, 10, 0, 0, 8'h00, 8'h00);
        add_row(OP_UNUSED, 127, 63, 1, 1, 8'h00, 8'h00);
        // Row 0 holds the top half of the corner block: column 0 and column 79.
        add_row(lacs_pkg::OP_STEP, 0, 0, 0, 1, 8'h01, 8'h80);
        // Row 1 sees only two live neighbors anywhere, so nothing is born.
        add_row(lacs_pkg::OP_STEP, 127, 63, 1, 1, 8'h00, 8'h00);
        // Mid generation: set and clear must be dropped.
        add_row(lacs_pkg::OP_SET, 1, 1, 1, 1, 8'h00, 8'h00);
        add_row(lacs_pkg::OP_CLEAR, 0, 0, 0, 1, 8'h00, 8'h00);
        add_row(OP_UNUSED, 0, 0, 0, 1, 8'h00, 8'h00);
        add_row(lacs_pkg::OP_STEP, 64, 32, 0, 0, 8'h00, 8'h00);
        foreach (script_rows[k])
            offer_item(script_rows[k].item, script_rows[k].known,
                       script_rows[k].first_bits, script_rows[k].last_bits);

        // Random part. It first finishes the running generation, then seeds a small random
        // patch of the board (anywhere, so it often wraps round an edge), sometimes after a
        // clear, and steps through the next generation. Noise mixed in: sets off the board,
        // the unused code, and sets and clears in the middle of a generation.
        while (counted < RANDOM_ITEMS)
        begin
            if (counted < 12)
                pace <= PACE_HOLD;
            else if (counted < 30)
                pace <= PACE_SENDER;
            else if (counted < 48)
                pace <= PACE_RECEIVER;
            else if (counted < 66)
                pace <= PACE_BOTH;
            else
                pace <= PACE_FREE;

            roll = $urandom_range(0, 99);
            it.x = 7'($urandom_range(0, 127));
            it.y = 6'($urandom_range(0, 63));
            it.v = 1'($urandom_range(0, 1));
            if (wipe_next)
            begin
                it.op = lacs_pkg::OP_CLEAR;
                wipe_next = 1'b0;
            end
            else if (seeds_left > 0 && roll < 8)
            begin
                it.op = lacs_pkg::OP_SET;
                if ($urandom_range(0, 1) == 0)
                    it.x = 7'($urandom_range(BOARD_COLS, 127));
                else
                    it.y = 6'($urandom_range(BOARD_ROWS, 63));
            end
            else if (seeds_left > 0 && roll < 12)
            begin
                it.op = OP_UNUSED;
            end
            else if (seeds_left > 0)
            begin
                it.op = lacs_pkg::OP_SET;
                it.x = 7'((seed_col + $urandom_range(0, 4)) % BOARD_COLS);
                it.y = 6'((seed_row + $urandom_range(0, 4)) % BOARD_ROWS);
                it.v = ($urandom_range(0, 9) < 7);
                seeds_left--;
            end
            else if (roll < 12)
            begin
                case ($urandom_range(0, 2))
                    0: it.op = lacs_pkg::OP_SET;
                    1: it.op = lacs_pkg::OP_CLEAR;
                    default: it.op = OP_UNUSED;
                endcase
            end
            else
            begin
                it.op = lacs_pkg::OP_STEP;
            end

            counts = (it.op == lacs_pkg::OP_STEP)
                  || (row_cursor == 0 && (it.op == lacs_pkg::OP_CLEAR
                      || (it.op == lacs_pkg::OP_SET && it.x < BOARD_COLS
                          && it.y < BOARD_ROWS)));
            offer_item(it, 1'b0, 8'h00, 8'h00);
            if (counts)
                counted++;

            // A step that brought the cursor back to row 0 closed a generation.
            if (it.op == lacs_pkg::OP_STEP && row_cursor == 0)
            begin
                seeds_left = $urandom_range(10, 20);
                seed_col = $urandom_range(0, BOARD_COLS - 1);
                seed_row = $urandom_range(0, BOARD_ROWS - 1);
                wipe_next = ($urandom_range(0, 3) == 0);
            end
        end
        item_valid <= 1'b0;
        pace <= PACE_FREE;

        // Let every expected result arrive, then give stray results time to show up.
        while (expected_groups.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // Run limit, many times the slowest correct run.
    initial
    begin : watchdog
        #(TIMEOUT_NS);
        $display("FAILED: results differ");
        $finish;
    end

endmodule

// ----- life_automaton_change_stream_top.f -----
src/lacs_pkg.sv
src/lacs_front.sv
src/lacs_queue.sv
src/lacs_back.sv
src/life_automaton_change_stream_top.sv
test/testbench.sv
